// ===== hdl/balm_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery average level monitor: shared types and constants
// Command and status records between controller and datapath, register
// indexes, reset values and level codes.
// ----------------------------------------------------------------------------
package balm_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MV_W        = 16;
    localparam int LEVEL_W     = 2;
    localparam int CHASE_W     = 2;
    localparam int ELAPSED_W   = 17;
    localparam int COUNT_W     = 8;
    localparam int QUOT_W      = 16;
    // Below saturation the dividend stays under divisor times 2^16, and the
    // divisor has 8 bits.
    localparam int DIVD_W      = COUNT_W + QUOT_W;
    // Shift of the reciprocal; exact for every divisor up to 255 over that range.
    localparam int RECIP_SHIFT = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MV_PER_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_MV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MV        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV       = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_PERIOD = 16'd10;
    localparam logic [CFG_DATA_W-1:0] RST_MV_PER_COUNT  = 16'd412;
    localparam logic [CFG_DATA_W-1:0] RST_CRITICAL_MV   = 16'd6000;
    localparam logic [CFG_DATA_W-1:0] RST_LOW_MV        = 16'd6600;
    localparam logic [CFG_DATA_W-1:0] RST_FULL_MV       = 16'd8400;

    localparam logic [LEVEL_W-1:0] LVL_NORMAL   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_LOW      = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_FULL     = 2'd3;

    typedef struct packed {
        logic capture;    // latch the incoming word
        logic tick;       // advance tick counter, take a sample if due
        logic mul;        // sum times scale factor
        logic div;        // saturation check and reciprocal division
        logic classify;   // compare against thresholds, update state
        logic load;       // move the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic avg_due;    // this tick completes an averaging window
    } dp_status_t;

endpackage

// ===== hdl/balm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Battery average level monitor: controller
// Sequences one tick at a time through sampling (and, on a window close, scaling,
// division and classification), and owns the output valid flag.
// ----------------------------------------------------------------------------
module balm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output balm_pkg::dp_cmd_t    cmd,
    input  balm_pkg::dp_status_t status
);
    import balm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_MUL,
        ST_DIV,
        ST_CLASS,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    // The output register may be refilled in the cycle its word leaves.
    assign load_fire = (state_reg == ST_LOAD) && (!out_valid_reg || m_ready);

    always_comb begin
        cmd          = '0;
        cmd.capture  = s_valid && (state_reg == ST_IDLE);
        cmd.tick     = (state_reg == ST_TICK);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div      = (state_reg == ST_DIV);
        cmd.classify = (state_reg == ST_CLASS);
        cmd.load     = load_fire;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_TICK;
            end
            ST_TICK: begin
                state_next = status.avg_due ? ST_MUL : ST_LOAD;
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (load_fire) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (load_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/balm_dp.sv =====
// ----------------------------------------------------------------------------
// Battery average level monitor: datapath
// Configuration registers, tick counter, sample accumulator, scaling
// multiplier, reciprocal constant divider, classifier and output register.
// ----------------------------------------------------------------------------
module balm_dp #(
    parameter int SAMPLES_PER_AVERAGE = 201,
    parameter int ADC_BITS            = 12,
    parameter int CHASE_LEDS          = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [balm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [balm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [ADC_BITS-1:0]                s_adc_sample,
    input  balm_pkg::dp_cmd_t                  cmd,
    output balm_pkg::dp_status_t               status,
    output logic                               m_evaluated,
    output logic [balm_pkg::MV_W-1:0]          m_voltage_mv,
    output logic [balm_pkg::LEVEL_W-1:0]       m_level,
    output logic [balm_pkg::CHASE_W-1:0]       m_chase_led,
    output logic                               m_clear_leds,
    output logic                               m_shutdown
);
    import balm_pkg::*;

    localparam int SUM_W   = ADC_BITS + COUNT_W;
    localparam int PROD_W  = SUM_W + CFG_DATA_W;
    localparam int X_W     = SUM_W + 8;
    localparam int CP_W    = (CHASE_LEDS > 2) ? $clog2(CHASE_LEDS) : 1;
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam int DPROD_W = DIVD_W + RECIP_W;
    // Reciprocal of the window length, rounded up.
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) /
        64'(SAMPLES_PER_AVERAGE);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_VAL);
    localparam logic [X_W-1:0]     SAT_LIMIT = X_W'(SAMPLES_PER_AVERAGE) << QUOT_W;
    localparam logic [COUNT_W-1:0] N_AVG     = COUNT_W'(SAMPLES_PER_AVERAGE);
    localparam logic [CP_W-1:0]    CP_LAST   = CP_W'(CHASE_LEDS - 1);

    // Configuration
    logic [CFG_DATA_W-1:0] period_reg, scale_reg, crit_reg, low_reg, full_reg;

    // Block state
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [CP_W-1:0]      chase_pos_reg;
    logic                 owned_reg;
    logic [MV_W-1:0]      last_mv_reg;

    // Working registers
    logic [ADC_BITS-1:0]  adc_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [QUOT_W-1:0]    quot_reg;

    // Pending result
    logic                 res_eval_reg;
    logic [LEVEL_W-1:0]   res_level_reg;
    logic [CHASE_W-1:0]   res_chase_reg;
    logic                 res_clr_reg;
    logic                 res_shut_reg;

    // Output register
    logic                 out_eval_reg;
    logic [MV_W-1:0]      out_mv_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    logic [CHASE_W-1:0]   out_chase_reg;
    logic                 out_clr_reg;
    logic                 out_shut_reg;

    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 take_sample;
    logic [COUNT_W-1:0]   count_inc;
    logic [X_W-1:0]       div_x;
    logic                 div_sat;
    logic [DPROD_W-1:0]   div_prod;
    logic [CP_W-1:0]      chase_pos_next;
    logic [CP_W+1:0]      chase_wide;

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign take_sample = elapsed_inc > ELAPSED_W'(period_reg);
    assign count_inc   = count_reg + 1'b1;
    assign div_x       = prod_reg[PROD_W-1:8];
    assign div_sat     = div_x >= SAT_LIMIT;
    // Below the saturation limit the rounded-up reciprocal gives the exact
    // floor of the quotient.
    assign div_prod    = div_x[DIVD_W-1:0] * RECIP;
    assign chase_pos_next = (chase_pos_reg == CP_LAST) ? '0 : chase_pos_reg + 1'b1;
    assign chase_wide  = (CP_W+2)'(chase_pos_next);

    assign status.avg_due = take_sample && (count_inc >= N_AVG);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= RST_SAMPLE_PERIOD;
            scale_reg  <= RST_MV_PER_COUNT;
            crit_reg   <= RST_CRITICAL_MV;
            low_reg    <= RST_LOW_MV;
            full_reg   <= RST_FULL_MV;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SAMPLE_PERIOD: period_reg <= cfg_data;
                REG_MV_PER_COUNT:  scale_reg  <= cfg_data;
                REG_CRITICAL_MV:   crit_reg   <= cfg_data;
                REG_LOW_MV:        low_reg    <= cfg_data;
                REG_FULL_MV:       full_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg   <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            chase_pos_reg <= '0;
            owned_reg     <= 1'b0;
            last_mv_reg   <= '0;
        end else if (cmd.tick) begin
            if (take_sample) begin
                elapsed_reg <= '0;
                sum_reg     <= sum_reg + SUM_W'(adc_reg);
                count_reg   <= count_inc;
            end else begin
                elapsed_reg <= elapsed_inc;
            end
        end else if (cmd.classify) begin
            last_mv_reg <= quot_reg;
            sum_reg     <= '0;
            count_reg   <= '0;
            if (quot_reg <= crit_reg) begin
                owned_reg <= 1'b1;
            end else if (quot_reg <= low_reg) begin
                owned_reg     <= 1'b1;
                chase_pos_reg <= chase_pos_next;
            end else if (quot_reg >= full_reg) begin
                owned_reg <= 1'b1;
            end else begin
                owned_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) adc_reg <= s_adc_sample;
        if (cmd.mul) prod_reg <= sum_reg * scale_reg;
        if (cmd.div) quot_reg <= div_sat ? '1 : div_prod[RECIP_SHIFT +: QUOT_W];

        if (cmd.tick) begin
            res_eval_reg  <= 1'b0;
            res_level_reg <= LVL_NORMAL;
            res_chase_reg <= '0;
            res_clr_reg   <= 1'b0;
            res_shut_reg  <= 1'b0;
        end else if (cmd.classify) begin
            res_eval_reg  <= 1'b1;
            res_chase_reg <= '0;
            res_clr_reg   <= 1'b0;
            res_shut_reg  <= 1'b0;
            if (quot_reg <= crit_reg) begin
                res_level_reg <= LVL_CRITICAL;
                res_shut_reg  <= 1'b1;
            end else if (quot_reg <= low_reg) begin
                res_level_reg <= LVL_LOW;
                res_chase_reg <= chase_wide[CHASE_W-1:0];
            end else if (quot_reg >= full_reg) begin
                res_level_reg <= LVL_FULL;
            end else begin
                res_level_reg <= LVL_NORMAL;
                res_clr_reg   <= owned_reg;
            end
        end

        if (cmd.load) begin
            out_eval_reg  <= res_eval_reg;
            out_mv_reg    <= last_mv_reg;
            out_level_reg <= res_level_reg;
            out_chase_reg <= res_chase_reg;
            out_clr_reg   <= res_clr_reg;
            out_shut_reg  <= res_shut_reg;
        end
    end

    assign m_evaluated  = out_eval_reg;
    assign m_voltage_mv = out_mv_reg;
    assign m_level      = out_level_reg;
    assign m_chase_led  = out_chase_reg;
    assign m_clear_leds = out_clr_reg;
    assign m_shutdown   = out_shut_reg;

endmodule

// ===== hdl/battery_average_level_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// Battery average level monitor
// Averages sampled battery ADC readings and classifies the mean voltage.
// ----------------------------------------------------------------------------
// Usage: each input word is one millisecond tick carrying the current ADC
// reading (s_valid/s_ready); every accepted tick yields exactly one result
// word (m_valid/m_ready) with the evaluation flag, the last averaged voltage
// in millivolts, the level code and the LED and shutdown flags.
// Timing: one tick is in flight at a time. A tick that does not close an
// averaging window passes through the tick and load states; a tick that
// closes one also passes, before the load, through the states for the
// scaling multiply, the division by the window length (a multiply by its
// reciprocal) and the classification. The result is written into the
// output register in the load state.
// The result sits in an output register, so the next tick is accepted while
// it waits; a stalled receiver only holds up the tick after that one.
// Reset (aresetn low, synchronous) restores the register defaults and
// clears counters, accumulator, chase position and the held voltage.
// Configuration writes (cfg_wr_en) take effect at once; unknown indexes are
// ignored.
// ----------------------------------------------------------------------------
module battery_average_level_monitor_unit #(
    parameter int SAMPLES_PER_AVERAGE = 201,
    parameter int ADC_BITS            = 12,
    parameter int CHASE_LEDS          = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [balm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [balm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ADC_BITS-1:0]             s_adc_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_evaluated,
    output logic [balm_pkg::MV_W-1:0]       m_voltage_mv,
    output logic [balm_pkg::LEVEL_W-1:0]    m_level,
    output logic [balm_pkg::CHASE_W-1:0]    m_chase_led,
    output logic                            m_clear_leds,
    output logic                            m_shutdown
);
    import balm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    balm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    balm_dp #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .ADC_BITS            (ADC_BITS),
        .CHASE_LEDS          (CHASE_LEDS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_adc_sample (s_adc_sample),
        .cmd          (cmd),
        .status       (status),
        .m_evaluated  (m_evaluated),
        .m_voltage_mv (m_voltage_mv),
        .m_level      (m_level),
        .m_chase_led  (m_chase_led),
        .m_clear_leds (m_clear_leds),
        .m_shutdown   (m_shutdown)
    );

    // A word without a new average carries no level or action flags.
    a_idle_word_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evaluated |->
            (m_level == LVL_NORMAL) && !m_shutdown && !m_clear_leds && (m_chase_led == '0))
        else $error("flags set on a word without evaluation");

    a_shutdown_critical: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_shutdown |-> (m_level == LVL_CRITICAL))
        else $error("shutdown outside the critical level");

    a_clear_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clear_leds |-> m_evaluated && (m_level == LVL_NORMAL))
        else $error("LED release outside the normal level");

    // Only one tick is worked on at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while a tick is in progress");

endmodule

// ===== test/battery_average_level_monitor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Battery average level monitor: self-checking testbench
// Sends millisecond tick words through the valid/ready input, predicts each
// result word with a cycle-free model of the averaging and classification,
// and checks every field of every result. Windows of constant readings walk
// the critical, low, full and normal levels, chase steps, LED release,
// exact thresholds, saturation, a zero scale and short sample periods;
// random phases follow with mixed idling on both channels and a forced
// back-pressure episode.
// ----------------------------------------------------------------------------
module battery_average_level_monitor_unit_tb;

    import balm_pkg::*;

    localparam int AVG_LEN          = 201;
    localparam int ADC_W            = 12;
    localparam int CHASE_COUNT      = 4;
    localparam int ADC_MAX          = (1 << ADC_W) - 1;
    localparam int SUM_W            = 20;
    localparam int AVG_DIVISOR      = AVG_LEN * 256;
    localparam int MV_LIMIT         = 65535;
    localparam int BOUNDARY_ADC     = 3000;
    localparam int DEFAULT_TICKS    = 44;
    localparam int PERIOD_ONE_TICKS = 20;
    localparam int RANDOM_TICKS     = 90;
    localparam int LONG_STALL       = 150;
    localparam int DRAIN_CYCLES     = 30;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int PRINT_CAP        = 40;

    typedef struct packed {
        logic              evaluated;
        logic [MV_W-1:0]   voltage_mv;
        logic [LEVEL_W-1:0] level;
        logic [CHASE_W-1:0] chase_led;
        logic              clear_leds;
        logic              shutdown;
    } tick_report_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [ADC_W-1:0]       s_adc_sample = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic                   m_evaluated;
    logic [MV_W-1:0]        m_voltage_mv;
    logic [LEVEL_W-1:0]     m_level;
    logic [CHASE_W-1:0]     m_chase_led;
    logic                   m_clear_leds;
    logic                   m_shutdown;

    battery_average_level_monitor_unit #(
        .SAMPLES_PER_AVERAGE(AVG_LEN),
        .ADC_BITS           (ADC_W),
        .CHASE_LEDS         (CHASE_COUNT)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_evaluated  (m_evaluated),
        .m_voltage_mv (m_voltage_mv),
        .m_level      (m_level),
        .m_chase_led  (m_chase_led),
        .m_clear_leds (m_clear_leds),
        .m_shutdown   (m_shutdown)
    );

    // Register shadows and monitor state as the block should hold them.
    logic [CFG_DATA_W-1:0] period_reg   = RST_SAMPLE_PERIOD;
    logic [CFG_DATA_W-1:0] scale_reg    = RST_MV_PER_COUNT;
    logic [CFG_DATA_W-1:0] critical_reg = RST_CRITICAL_MV;
    logic [CFG_DATA_W-1:0] low_reg      = RST_LOW_MV;
    logic [CFG_DATA_W-1:0] full_reg     = RST_FULL_MV;

    logic [ELAPSED_W-1:0] tick_gap     = '0;
    logic [SUM_W-1:0]     adc_total    = '0;
    logic [COUNT_W-1:0]   sample_tally = '0;
    logic [CHASE_W-1:0]   chase_at     = '0;
    logic                 leds_held    = 1'b0;
    logic [MV_W-1:0]      held_mv      = '0;

    logic [ADC_W-1:0] tick_words[$];
    tick_report_t     due_reports[$];

    bit word_taken     = 1'b0;
    bit send_hold      = 1'b0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_request  = 0;
    int stall_left     = 0;

    int unsigned cycle_count   = 0;
    int          fault_count   = 0;
    int          ticks_checked = 0;
    int          averages_seen = 0;
    int          saturations   = 0;
    int          level_tally[4];

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic tick_report_t forecast_tick(input logic [ADC_W-1:0] adc);
        tick_report_t r;
        logic [SUM_W+CFG_DATA_W-1:0] scaled;
        logic [SUM_W+CFG_DATA_W-1:0] mean_mv;
        r = '0;
        if (tick_gap != '1) tick_gap++;
        if (tick_gap > period_reg) begin
            tick_gap = '0;
            adc_total += adc;
            sample_tally++;
            if (sample_tally >= AVG_LEN) begin
                scaled  = adc_total * scale_reg;
                mean_mv = scaled / AVG_DIVISOR;
                held_mv = (mean_mv > MV_LIMIT) ? '1 : mean_mv[MV_W-1:0];
                adc_total    = '0;
                sample_tally = '0;
                r.evaluated  = 1'b1;
                if (held_mv <= critical_reg) begin
                    r.level    = LVL_CRITICAL;
                    r.shutdown = 1'b1;
                    leds_held  = 1'b1;
                end else if (held_mv <= low_reg) begin
                    r.level   = LVL_LOW;
                    leds_held = 1'b1;
                    // Four chase positions, so the 2-bit wrap is the modulo.
                    chase_at++;
                    r.chase_led = chase_at;
                end else if (held_mv >= full_reg) begin
                    r.level   = LVL_FULL;
                    leds_held = 1'b1;
                end else begin
                    r.level      = LVL_NORMAL;
                    r.clear_leds = leds_held;
                    leds_held    = 1'b0;
                end
            end
        end
        r.voltage_mv = held_mv;
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fault_count++;
            if (fault_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Input driver: a fresh word is offered only once the previous one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (tick_words.size() != 0 && !send_hold &&
                $urandom_range(99) >= send_idle_pct) begin
                s_valid      <= 1'b1;
                s_adc_sample <= tick_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with random stalls and an occasional long hold-off.
    always @(negedge aclk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        tick_report_t want;
        if (!aresetn) begin
            word_taken = 1'b0;
        end else begin
            // Results are checked before the new tick is predicted: a word
            // cannot come out at the same edge as the tick that causes it.
            if (m_valid && m_ready) begin
                if (due_reports.size() == 0) begin
                    fault_count++;
                    if (fault_count <= PRINT_CAP)
                        $display("%0t: result word with nothing expected, got voltage_mv %0d",
                                 $time, m_voltage_mv);
                end else begin
                    want = due_reports.pop_front();
                    check_field("evaluated", want.evaluated, m_evaluated);
                    check_field("voltage_mv", want.voltage_mv, m_voltage_mv);
                    check_field("level", want.level, m_level);
                    check_field("chase_led", want.chase_led, m_chase_led);
                    check_field("clear_leds", want.clear_leds, m_clear_leds);
                    check_field("shutdown", want.shutdown, m_shutdown);
                    ticks_checked++;
                    if (want.evaluated) begin
                        averages_seen++;
                        level_tally[want.level]++;
                        if (want.voltage_mv == '1) saturations++;
                    end
                end
            end
            word_taken = s_valid && s_ready;
            if (word_taken) due_reports.push_back(forecast_tick(s_adc_sample));
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
            $display("** battery_average_level_monitor_unit: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SAMPLE_PERIOD: period_reg   = val;
            REG_MV_PER_COUNT:  scale_reg    = val;
            REG_CRITICAL_MV:   critical_reg = val;
            REG_LOW_MV:        low_reg      = val;
            REG_FULL_MV:       full_reg     = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until no word is in flight and every result has come back.
    // Words held back by the sender pause do not count as in flight.
    task automatic settle();
        @(posedge aclk);
        while (s_valid || due_reports.size() != 0 ||
               (tick_words.size() != 0 && !send_hold))
            @(posedge aclk);
    endtask

    task automatic queue_ticks(input int n, input int centre, input int spread);
        int a;
        repeat (n) begin
            a = centre + int'($urandom_range(2 * spread)) - spread;
            if (a < 0) a = 0;
            if (a > ADC_MAX) a = ADC_MAX;
            tick_words.push_back(ADC_W'(a));
        end
    endtask

    // With a zero sample period this closes the current averaging window.
    task automatic fill_window(input int centre, input int spread);
        settle();
        queue_ticks(AVG_LEN - sample_tally, centre, spread);
    endtask

    function automatic int adc_for_mv(input int mv);
        int a;
        if (scale_reg == 0) return $urandom_range(ADC_MAX);
        a = (mv * 256 + scale_reg - 1) / scale_reg;
        return (a > ADC_MAX) ? ADC_MAX : a;
    endfunction

    function automatic int random_target();
        case ($urandom_range(3))
            0: return $urandom_range(critical_reg);
            1: return $urandom_range(critical_reg, low_reg);
            2: return $urandom_range(low_reg, full_reg);
            default: return int'(full_reg) + $urandom_range(1500);
        endcase
    endfunction

    task automatic random_phase(input int n, input int idle_pct, input int stall_pct,
                                input bit pressure);
        int lo, mid, hi, chunk, queued;
        settle();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(REG_SAMPLE_PERIOD,
                  ($urandom_range(9) < 7) ? 16'd0 : 16'($urandom_range(1, 3)));
        write_reg(REG_MV_PER_COUNT, 16'($urandom_range(300, 1000)));
        lo  = $urandom_range(2000, 6000);
        mid = $urandom_range(lo, lo + 3000);
        hi  = $urandom_range(mid, mid + 4000);
        if ($urandom_range(4) == 0) begin
            // Thresholds out of order: the critical test wins over the others.
            write_reg(REG_CRITICAL_MV, 16'(hi));
            write_reg(REG_LOW_MV, 16'(lo));
            write_reg(REG_FULL_MV, 16'(mid));
        end else begin
            write_reg(REG_CRITICAL_MV, 16'(lo));
            write_reg(REG_LOW_MV, 16'(mid));
            write_reg(REG_FULL_MV, 16'(hi));
        end
        queued = 0;
        while (queued < n) begin
            chunk = $urandom_range(40, AVG_LEN);
            if (chunk > n - queued) chunk = n - queued;
            if ($urandom_range(9) == 0)
                queue_ticks(chunk, ADC_MAX / 2, ADC_MAX / 2 + 1);
            else
                queue_ticks(chunk, adc_for_mv(random_target()), $urandom_range(8));
            queued += chunk;
        end
        if (pressure) begin
            @(posedge aclk);
            stall_request = LONG_STALL;
            while (tick_words.size() > n / 2) @(posedge aclk);
            send_hold = 1'b1;
            settle();
            send_hold = 1'b0;
        end
    endtask

    initial begin
        int boundary_mv;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: a few samples at the default period; the tick words
        // open with the extreme readings.
        queue_ticks(1, 0, 0);
        queue_ticks(1, ADC_MAX, 0);
        queue_ticks(1, 'hAAA, 0);
        queue_ticks(1, 'h555, 0);
        queue_ticks(DEFAULT_TICKS - 4, 3900, 150);
        settle();

        write_reg(REG_SAMPLE_PERIOD, 16'd0);
        write_reg(REG_MV_PER_COUNT, 16'd600);
        write_reg(REG_CRITICAL_MV, 16'd6000);
        write_reg(REG_LOW_MV, 16'd6600);
        write_reg(REG_FULL_MV, 16'd8400);
        // Writes to unused indexes must leave every register alone.
        for (int idx = REG_FULL_MV + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), 16'($urandom));

        fill_window(adc_for_mv(6300), 4);

        // A constant reading gives an exact voltage, so each threshold can
        // be placed right on it.
        boundary_mv = (BOUNDARY_ADC * scale_reg) >> 8;
        settle();
        write_reg(REG_CRITICAL_MV, 16'(boundary_mv));
        fill_window(BOUNDARY_ADC, 0);
        settle();
        write_reg(REG_CRITICAL_MV, 16'(boundary_mv - 1));
        write_reg(REG_LOW_MV, 16'(boundary_mv));
        fill_window(BOUNDARY_ADC, 0);
        settle();
        write_reg(REG_LOW_MV, 16'(boundary_mv - 1));
        write_reg(REG_FULL_MV, 16'(boundary_mv));
        fill_window(BOUNDARY_ADC, 0);
        settle();
        write_reg(REG_FULL_MV, 16'(boundary_mv + 1));
        fill_window(BOUNDARY_ADC, 0);

        settle();
        write_reg(REG_MV_PER_COUNT, 16'hFFFF);
        write_reg(REG_CRITICAL_MV, 16'd0);
        write_reg(REG_LOW_MV, 16'd0);
        write_reg(REG_FULL_MV, 16'hFFFF);
        fill_window(ADC_MAX, 0);
        settle();
        write_reg(REG_MV_PER_COUNT, 16'd0);
        fill_window(ADC_MAX, 0);

        settle();
        write_reg(REG_SAMPLE_PERIOD, 16'd1);
        write_reg(REG_CRITICAL_MV, 16'd6000);
        write_reg(REG_LOW_MV, 16'd6600);
        write_reg(REG_FULL_MV, 16'd8400);
        queue_ticks(PERIOD_ONE_TICKS, adc_for_mv(7000), 30);

        random_phase(RANDOM_TICKS, 0, 0, 1'b1);
        random_phase(RANDOM_TICKS, 47, 0, 1'b0);
        random_phase(RANDOM_TICKS, 0, 47, 1'b0);
        random_phase(RANDOM_TICKS, 37, 37, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d result words over %0d averages: %0d critical, %0d low, %0d full,",
                 ticks_checked, averages_seen, level_tally[LVL_CRITICAL],
                 level_tally[LVL_LOW], level_tally[LVL_FULL]);
        $display("%0d normal, %0d saturated; %0d mismatches in total.",
                 level_tally[LVL_NORMAL], saturations, fault_count);
        if (fault_count == 0) begin
            $display("** battery_average_level_monitor_unit: PASSED **");
        end else begin
            $display("** battery_average_level_monitor_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/balm_pkg.sv
hdl/balm_ctrl.sv
hdl/balm_dp.sv
hdl/battery_average_level_monitor_unit.sv
test/battery_average_level_monitor_unit_tb.sv
